// ===== hw/rtl/bqc_pkg.sv =====
package bqc_pkg;

  localparam int ST_W      = 32;
  localparam int COEF_BITS = 26;
  localparam int NUM_SECT  = 3;
  localparam int DATA_W    = 32;
  localparam int ADDR_W    = 5;

  typedef logic [ADDR_W-3:0] reg_idx_t;

  localparam reg_idx_t REG_BYPASS     = reg_idx_t'(0);
  localparam reg_idx_t REG_STAGE1_FB1 = reg_idx_t'(1);

  typedef struct packed {
    logic              restart;
    logic signed [ST_W-1:0] seed;
    logic signed [ST_W-1:0] x;
  } link_t;

  function automatic int coef_width(int frac_bits);
    int mx;
    mx = (frac_bits > COEF_BITS) ? frac_bits : COEF_BITS;
    return mx + 2;
  endfunction

  function automatic reg_idx_t fb_index(int sect, int second);
    return reg_idx_t'(int'(REG_STAGE1_FB1) + 2 * sect + second);
  endfunction

endpackage

// ===== hw/rtl/bqc_cfg.sv =====
module bqc_cfg #(
  parameter int COEF_FRAC_BITS = 24,
  localparam int CW = bqc_pkg::coef_width(COEF_FRAC_BITS)
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [bqc_pkg::ADDR_W-1:0]          paddr,
  input  logic [bqc_pkg::DATA_W-1:0]          pwdata,
  output logic [bqc_pkg::DATA_W-1:0]          prdata,
  output logic                                pready,
  output logic                                bypass,
  output logic signed [bqc_pkg::COEF_BITS-1:0] fb1 [bqc_pkg::NUM_SECT],
  output logic signed [bqc_pkg::COEF_BITS-1:0] fb2 [bqc_pkg::NUM_SECT],
  output logic signed [CW-1:0]                b0  [bqc_pkg::NUM_SECT]
);

  localparam logic signed [CW-1:0] ONE = CW'(1) <<< COEF_FRAC_BITS;

  bqc_pkg::reg_idx_t                    idx;
  logic                                 wr;
  logic signed [bqc_pkg::COEF_BITS-1:0] wcoef;
  logic signed [bqc_pkg::COEF_BITS-1:0] fb1_next [bqc_pkg::NUM_SECT];
  logic signed [bqc_pkg::COEF_BITS-1:0] fb2_next [bqc_pkg::NUM_SECT];
  logic signed [CW-1:0]                 b0_next  [bqc_pkg::NUM_SECT];

  assign pready = 1'b1;
  assign idx    = paddr[bqc_pkg::ADDR_W-1:2];
  assign wr     = psel && penable && pwrite && pready;
  assign wcoef  = signed'(pwdata[bqc_pkg::COEF_BITS-1:0]);

  // b0 = b2 = floor((ONE + a1 + a2) / 4), kept next to the feedback pair
  always_comb begin
    for (int s = 0; s < bqc_pkg::NUM_SECT; s++) begin
      fb1_next[s] = fb1[s];
      fb2_next[s] = fb2[s];
      if (wr && idx == bqc_pkg::fb_index(s, 0)) begin
        fb1_next[s] = wcoef;
      end
      if (wr && idx == bqc_pkg::fb_index(s, 1)) begin
        fb2_next[s] = wcoef;
      end
      b0_next[s] = (ONE + CW'(fb1_next[s]) + CW'(fb2_next[s])) >>> 2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bypass <= 1'b1;
      for (int s = 0; s < bqc_pkg::NUM_SECT; s++) begin
        fb1[s] <= '0;
        fb2[s] <= '0;
        b0[s]  <= ONE >>> 2;
      end
    end else begin
      if (wr && idx == bqc_pkg::REG_BYPASS) begin
        bypass <= pwdata[0];
      end
      for (int s = 0; s < bqc_pkg::NUM_SECT; s++) begin
        fb1[s] <= fb1_next[s];
        fb2[s] <= fb2_next[s];
        b0[s]  <= b0_next[s];
      end
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      bqc_pkg::REG_BYPASS: prdata = bqc_pkg::DATA_W'(bypass);
      default: begin
        for (int s = 0; s < bqc_pkg::NUM_SECT; s++) begin
          if (idx == bqc_pkg::fb_index(s, 0)) begin
            prdata = bqc_pkg::DATA_W'(fb1[s]);
          end
          if (idx == bqc_pkg::fb_index(s, 1)) begin
            prdata = bqc_pkg::DATA_W'(fb2[s]);
          end
        end
      end
    endcase
  end

endmodule

// ===== hw/rtl/bqc_cell.sv =====
module bqc_cell #(
  parameter int COEF_FRAC_BITS = 24,
  localparam int CW = bqc_pkg::coef_width(COEF_FRAC_BITS)
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  bqc_pkg::link_t                      in_data,
  input  logic signed [bqc_pkg::COEF_BITS-1:0] fb1,
  input  logic signed [bqc_pkg::COEF_BITS-1:0] fb2,
  input  logic signed [CW-1:0]                b0,
  output logic                                out_valid,
  input  logic                                out_stall,
  output bqc_pkg::link_t                      out_data
);

  localparam int ST_W = bqc_pkg::ST_W;
  localparam int PW   = CW + ST_W;
  localparam int SW   = PW + 3;
  localparam logic signed [SW-1:0] RND    = SW'(1) <<< (COEF_FRAC_BITS - 1);
  localparam logic signed [SW-1:0] SAT_HI = (SW'(1) <<< (ST_W - 1)) - SW'(1);
  localparam logic signed [SW-1:0] SAT_LO = -(SW'(1) <<< (ST_W - 1));

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SUM,
    ST_FIN
  } state_t;

  state_t                 st;
  logic                   accept;
  logic                   rs;
  logic signed [ST_W-1:0] sd;
  logic signed [CW-1:0]   b1;
  logic signed [ST_W-1:0] xin;
  logic signed [ST_W-1:0] x1, x2, y1, y2;
  logic signed [ST_W-1:0] xo1, xo2, yo1, yo2;
  logic signed [PW-1:0]   m0, m1, m2, m3, m4;
  logic signed [PW-1:0]   p0, p1, p2, p3, p4;
  logic signed [SW-1:0]   s0, s1, acc, shr;
  logic signed [ST_W-1:0] y;

  assign in_stall = (st != ST_IDLE) || (out_valid && out_stall);
  assign accept   = in_valid && !in_stall;
  assign b1       = b0 <<< 1;
  assign xin      = in_data.x;

  // seed the delay line with the scaled cascade input on restart
  always_comb begin
    xo1 = in_data.restart ? in_data.seed : x1;
    xo2 = in_data.restart ? in_data.seed : x2;
    yo1 = in_data.restart ? in_data.seed : y1;
    yo2 = in_data.restart ? in_data.seed : y2;
    m0  = b0 * xin;
    m1  = b1 * xo1;
    m2  = b0 * xo2;
    m3  = fb1 * yo1;
    m4  = fb2 * yo2;
  end

  always_comb begin
    acc = s0 + s1 + RND;
    shr = acc >>> COEF_FRAC_BITS;
    if (shr > SAT_HI) begin
      y = ST_W'(SAT_HI);
    end else if (shr < SAT_LO) begin
      y = ST_W'(SAT_LO);
    end else begin
      y = ST_W'(shr);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= ST_IDLE;
      out_valid <= 1'b0;
      x1        <= '0;
      x2        <= '0;
      y1        <= '0;
      y2        <= '0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (st)
        ST_IDLE: begin
          if (accept) begin
            p0 <= m0;
            p1 <= m1;
            p2 <= m2;
            p3 <= m3;
            p4 <= m4;
            x1 <= xin;
            x2 <= xo1;
            y2 <= yo1;
            rs <= in_data.restart;
            sd <= in_data.seed;
            st <= ST_SUM;
          end
        end
        ST_SUM: begin
          s0 <= SW'(p0) + SW'(p1) + SW'(p2);
          s1 <= -(SW'(p3) + SW'(p4));
          st <= ST_FIN;
        end
        ST_FIN: begin
          y1               <= y;
          out_data.x       <= y;
          out_data.seed    <= sd;
          out_data.restart <= rs;
          out_valid        <= 1'b1;
          st               <= ST_IDLE;
        end
        default: st <= ST_IDLE;
      endcase
    end
  end

  a_fin_free: assert property (@(posedge clk) disable iff (rst)
    st == ST_FIN |-> !out_valid)
    else $error("section result register still occupied at finish");

  a_sum_fin: assert property (@(posedge clk) disable iff (rst)
    st == ST_SUM |=> st == ST_FIN)
    else $error("section sequence skipped its final step");

  a_rise_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(st) == ST_FIN)
    else $error("section result raised outside its final step");

endmodule

// ===== hw/rtl/butterworth_lowpass_biquad_cascade_top.sv =====
// Channel   Direction  Handshake              Payload
// in        into       in_valid / in_stall    sample, restart
// out       out of     out_valid / out_stall  filtered
// cfg       into       APB psel/penable       paddr, pwdata, prdata
//
// Each section holds one sample through multiply, sum and round (its product, sum
// and result registers), set by its feedback loop; the three sections overlap.
// A bypassed sample shows out_valid in the cycle after it is accepted.
// Reset is synchronous: bypass set, feedback coefficients and delay state cleared.
// A stall on the output holds the result and backs up through the sections.
module butterworth_lowpass_biquad_cascade_top #(
  parameter int SAMPLE_BITS    = 24,
  parameter int COEF_FRAC_BITS = 24,
  parameter int GUARD_BITS     = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic                          restart,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] filtered,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bqc_pkg::ADDR_W-1:0]    paddr,
  input  logic [bqc_pkg::DATA_W-1:0]    pwdata,
  output logic [bqc_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);

  localparam int ST_W = bqc_pkg::ST_W;
  localparam int NS   = bqc_pkg::NUM_SECT;
  localparam int CW   = bqc_pkg::coef_width(COEF_FRAC_BITS);
  localparam int XW   = (SAMPLE_BITS + GUARD_BITS + 1 > ST_W + 1) ?
                        SAMPLE_BITS + GUARD_BITS + 1 : ST_W + 1;
  localparam int YW   = ST_W + 1;
  localparam logic signed [XW-1:0] X_HI  = (XW'(1) <<< (ST_W - 1)) - XW'(1);
  localparam logic signed [XW-1:0] X_LO  = -(XW'(1) <<< (ST_W - 1));
  localparam logic signed [YW-1:0] Y_RND = (GUARD_BITS == 0) ? YW'(0) :
                                           (YW'(1) <<< (GUARD_BITS - 1));
  localparam logic signed [YW-1:0] Y_HI  = (YW'(1) <<< (SAMPLE_BITS - 1)) - YW'(1);
  localparam logic signed [YW-1:0] Y_LO  = -(YW'(1) <<< (SAMPLE_BITS - 1));

  logic                                 bypass;
  logic signed [bqc_pkg::COEF_BITS-1:0] fb1 [NS];
  logic signed [bqc_pkg::COEF_BITS-1:0] fb2 [NS];
  logic signed [CW-1:0]                 b0  [NS];

  logic [NS:0]            link_valid;
  logic [NS:0]            link_stall;
  bqc_pkg::link_t         link [NS+1];

  logic signed [XW-1:0]          xw;
  logic signed [ST_W-1:0]        xs;
  logic signed [ST_W-1:0]        y3;
  logic signed [YW-1:0]          yr;
  logic signed [SAMPLE_BITS-1:0] fout;
  logic                          load;

  bqc_cfg #(
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) u_cfg (
    .clk    (clk),
    .rst    (rst),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .bypass (bypass),
    .fb1    (fb1),
    .fb2    (fb2),
    .b0     (b0)
  );

  always_comb begin
    xw = XW'(sample) <<< GUARD_BITS;
    if (xw > X_HI) begin
      xs = ST_W'(X_HI);
    end else if (xw < X_LO) begin
      xs = ST_W'(X_LO);
    end else begin
      xs = ST_W'(xw);
    end
  end

  assign link_valid[0]      = in_valid && !bypass;
  assign link[0].x          = xs;
  assign link[0].seed       = xs;
  assign link[0].restart    = restart;
  assign link_stall[NS]     = out_valid && out_stall;
  assign in_stall           = bypass ? (out_valid && out_stall) : link_stall[0];

  for (genvar s = 0; s < NS; s++) begin : g_sect
    bqc_cell #(
      .COEF_FRAC_BITS(COEF_FRAC_BITS)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .in_valid (link_valid[s]),
      .in_stall (link_stall[s]),
      .in_data  (link[s]),
      .fb1      (fb1[s]),
      .fb2      (fb2[s]),
      .b0       (b0[s]),
      .out_valid(link_valid[s+1]),
      .out_stall(link_stall[s+1]),
      .out_data (link[s+1])
    );
  end

  always_comb begin
    y3 = link[NS].x;
    yr = (YW'(y3) + Y_RND) >>> GUARD_BITS;
    if (yr > Y_HI) begin
      fout = SAMPLE_BITS'(Y_HI);
    end else if (yr < Y_LO) begin
      fout = SAMPLE_BITS'(Y_LO);
    end else begin
      fout = SAMPLE_BITS'(yr);
    end
  end

  assign load = bypass ? (in_valid && !in_stall) : (link_valid[NS] && !link_stall[NS]);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (load) begin
        out_valid <= 1'b1;
        filtered  <= bypass ? sample : fout;
      end
    end
  end

  a_bypass_pass: assert property (@(posedge clk) disable iff (rst)
    bypass && in_valid && !in_stall |=> out_valid && filtered == $past(sample))
    else $error("bypassed transaction did not pass through unchanged");

endmodule

// ===== sim/butterworth_lowpass_biquad_cascade_top_test.sv =====
module butterworth_lowpass_biquad_cascade_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SAMPLE_W   = 24;
  localparam int FRAC_W     = 24;
  localparam int GUARD_W    = 8;
  localparam int DATA_W     = bqc_pkg::DATA_W;
  localparam int COEF_W     = bqc_pkg::COEF_BITS;
  localparam int SECTIONS   = bqc_pkg::NUM_SECT;
  localparam int ITEMS      = 1950;
  localparam int SETTINGS_N = 10;
  localparam int FLUSH      = 16;
  localparam int NPROBE     = 16;

  localparam longint ST_HI   = 64'sd2147483647;
  localparam longint ST_LO   = -64'sd2147483648;
  localparam longint OUT_HI  = 64'sd8388607;
  localparam longint OUT_LO  = -64'sd8388608;
  localparam longint COEF_HI = 64'sd33554431;
  localparam longint COEF_LO = -64'sd33554432;

  localparam logic signed [SAMPLE_W-1:0] S_MAX = 24'sh7FFFFF;
  localparam logic signed [SAMPLE_W-1:0] S_MIN = 24'sh800000;

  typedef enum int {
    R_BYPASS = 0,
    R_S1_FB1,
    R_S1_FB2,
    R_S2_FB1,
    R_S2_FB2,
    R_S3_FB1,
    R_S3_FB2,
    R_SPARE
  } reg_sel_t;

  typedef logic [bqc_pkg::ADDR_W-1:0] apb_addr_t;

  typedef struct packed {
    logic                       byp;
    logic                       seed;
    logic                       known;
    logic signed [SAMPLE_W-1:0] smp;
    logic signed [SAMPLE_W-1:0] want;
  } probe_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic signed [SAMPLE_W-1:0] sample = '0;
  logic                       restart = 1'b0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic signed [SAMPLE_W-1:0] filtered;
  logic                       psel = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite = 1'b0;
  apb_addr_t                  paddr = '0;
  logic [DATA_W-1:0]          pwdata = '0;
  logic [DATA_W-1:0]          prdata;
  logic                       pready;

  bit     bypass_q = 1'b1;
  longint fb [SECTIONS][2];
  longint hist_x [2*SECTIONS];
  longint hist_y [2*SECTIONS];
  longint plan_fb [2*SECTIONS];

  logic signed [SAMPLE_W-1:0] pending_filtered [$];
  bit                         pin_on = 1'b0;
  logic signed [SAMPLE_W-1:0] pin_val = '0;
  int                         src_gap_pct = 0;
  int                         sink_stall_pct = 0;
  int                         errors = 0;

  probe_t probes [NPROBE] = '{
    '{1'b1, 1'b0, 1'b1, S_MAX, S_MAX},
    '{1'b1, 1'b1, 1'b1, S_MIN, S_MIN},
    '{1'b1, 1'b0, 1'b1, 24'sh000000, 24'sh000000},
    '{1'b1, 1'b1, 1'b1, 24'shFFFFFF, 24'shFFFFFF},
    '{1'b1, 1'b0, 1'b1, 24'sh555555, 24'sh555555},
    '{1'b1, 1'b0, 1'b1, 24'shAAAAAA, 24'shAAAAAA},
    '{1'b0, 1'b1, 1'b1, S_MAX, S_MAX},
    '{1'b0, 1'b0, 1'b0, S_MIN, 24'sh000000},
    '{1'b0, 1'b0, 1'b0, S_MAX, 24'sh000000},
    '{1'b0, 1'b1, 1'b1, S_MIN, S_MIN},
    '{1'b0, 1'b0, 1'b0, 24'sh000001, 24'sh000000},
    '{1'b0, 1'b0, 1'b0, 24'shFFFFFF, 24'sh000000},
    '{1'b0, 1'b1, 1'b1, 24'sh000000, 24'sh000000},
    '{1'b0, 1'b0, 1'b0, 24'sh123456, 24'sh000000},
    '{1'b0, 1'b1, 1'b1, 24'shFFFFFF, 24'shFFFFFF},
    '{1'b0, 1'b0, 1'b0, 24'sh400000, 24'sh000000}
  };

  butterworth_lowpass_biquad_cascade_top #(
    .SAMPLE_BITS   (SAMPLE_W),
    .COEF_FRAC_BITS(FRAC_W),
    .GUARD_BITS    (GUARD_W)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sample   (sample),
    .restart  (restart),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .filtered (filtered),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic longint clip(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] biquad_cascade_predict(
      input logic signed [SAMPLE_W-1:0] s, input logic seed);
    longint x, y, acc, a1, a2, b0;
    int     k;
    if (bypass_q)
      return s;
    x = clip(longint'(s) * (longint'(1) <<< GUARD_W), ST_LO, ST_HI);
    if (seed) begin
      for (k = 0; k < 2*SECTIONS; k++) begin
        hist_x[k] = x;
        hist_y[k] = x;
      end
    end
    for (k = 0; k < SECTIONS; k++) begin
      a1  = fb[k][0];
      a2  = fb[k][1];
      b0  = ((longint'(1) <<< FRAC_W) + a1 + a2) >>> 2;
      acc = b0 * x + 2 * b0 * hist_x[2*k] + b0 * hist_x[2*k+1]
            - a1 * hist_y[2*k] - a2 * hist_y[2*k+1];
      y = clip((acc + (longint'(1) <<< (FRAC_W-1))) >>> FRAC_W, ST_LO, ST_HI);
      hist_x[2*k+1] = hist_x[2*k];
      hist_x[2*k]   = x;
      hist_y[2*k+1] = hist_y[2*k];
      hist_y[2*k]   = y;
      x = y;
    end
    y = clip((x + (longint'(1) <<< (GUARD_W-1))) >>> GUARD_W, OUT_LO, OUT_HI);
    return y[SAMPLE_W-1:0];
  endfunction

  function automatic void apply_reg(input reg_sel_t idx, input logic [DATA_W-1:0] data);
    int k;
    if (idx == R_BYPASS) begin
      bypass_q = data[0];
    end else if (idx <= R_S3_FB2) begin
      k = int'(idx) - int'(R_S1_FB1);
      fb[k/2][k%2] = longint'(signed'(data[COEF_W-1:0]));
    end
  endfunction

  function automatic longint to_q24(input real a);
    return longint'($rtoi(a * 16777216.0 + ((a < 0.0) ? -0.5 : 0.5)));
  endfunction

  function automatic real damping(input int s);
    case (s)
      0:       return 0.51763809;
      1:       return 2.0 * 0.70710678;
      default: return 1.93185165;
    endcase
  endfunction

  function automatic void plan_butterworth(input real fc);
    real kk, d, nrm;
    int  s;
    kk = $tan(3.14159265358979 * fc);
    for (s = 0; s < SECTIONS; s++) begin
      d   = damping(s);
      nrm = 1.0 / (1.0 + d * kk + kk * kk);
      plan_fb[2*s]   = to_q24(2.0 * (kk * kk - 1.0) * nrm);
      plan_fb[2*s+1] = to_q24((1.0 - d * kk + kk * kk) * nrm);
    end
  endfunction

  function automatic longint coef_pick(input bit mixed);
    int r;
    r = mixed ? $urandom_range(0, 2) : 2;
    case (r)
      0:       return COEF_HI;
      1:       return COEF_LO;
      default: return longint'($urandom_range(0, 32'h3FFFFFF)) + COEF_LO;
    endcase
  endfunction

  function automatic void set_idling(input int stage);
    case (stage)
      0: begin
        src_gap_pct    = 34;
        sink_stall_pct = 69;
      end
      1: begin
        src_gap_pct    = 69;
        sink_stall_pct = 34;
      end
      default: begin
        src_gap_pct    = 0;
        sink_stall_pct = 0;
      end
    endcase
  endfunction

  task automatic apb_write(input reg_sel_t idx, input logic [DATA_W-1:0] data);
    logic [DATA_W-1:0] mask;
    mask = (idx == R_BYPASS) ? DATA_W'(1) : ((DATA_W'(1) << COEF_W) - 1);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= apb_addr_t'(4 * int'(idx));
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    apply_reg(idx, data);
    if (idx != R_SPARE) begin
      @(negedge clk);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clk);
      penable <= 1'b1;
      do @(posedge clk); while (!pready);
      if ((prdata & mask) !== (data & mask)) begin
        $display("%0t register %0d readback: expected %h actual %h",
                 $time, int'(idx), data & mask, prdata & mask);
        errors++;
      end
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic program_all(input logic byp);
    int j;
    for (j = 0; j < 2*SECTIONS; j++)
      apb_write(reg_sel_t'(int'(R_S1_FB1) + j), plan_fb[j][DATA_W-1:0]);
    apply_reg(R_SPARE, '0);
    apb_write(R_SPARE, $urandom());
    apb_write(R_BYPASS, DATA_W'(byp));
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_filtered.size() != 0)
      @(posedge clk);
    repeat (FLUSH) @(posedge clk);
  endtask

  task automatic push_sample(input logic signed [SAMPLE_W-1:0] s, input logic seed,
                             input bit known, input logic signed [SAMPLE_W-1:0] want);
    @(negedge clk);
    pin_on  = known;
    pin_val = want;
    while (src_gap_pct != 0 && $urandom_range(0, 99) < src_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    sample   <= s;
    restart  <= seed;
    do @(posedge clk); while (in_stall);
  endtask

  always @(negedge clk) begin
    out_stall <= (sink_stall_pct != 0) && ($urandom_range(0, 99) < sink_stall_pct);
  end

  always @(posedge clk) begin : scoreboard
    logic signed [SAMPLE_W-1:0] want;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        want = biquad_cascade_predict(sample, restart);
        if (pin_on)
          want = pin_val;
        pending_filtered.push_back(want);
      end
      if (out_valid && !out_stall) begin
        if (pending_filtered.size() == 0) begin
          $display("%0t unexpected output: expected none actual %0d", $time, filtered);
          errors++;
        end else begin
          want = pending_filtered.pop_front();
          if (filtered !== want) begin
            $display("%0t filtered mismatch: expected %0d actual %0d", $time, want, filtered);
            errors++;
          end
        end
      end
    end
  end

  initial begin : stimulus
    int                         n, k, phase, choice, per_phase;
    logic                       seed;
    logic signed [SAMPLE_W-1:0] s, level;
    for (k = 0; k < SECTIONS; k++) begin
      fb[k][0] = 0;
      fb[k][1] = 0;
    end
    for (k = 0; k < 2*SECTIONS; k++) begin
      hist_x[k]  = 0;
      hist_y[k]  = 0;
      plan_fb[k] = 0;
    end
    set_idling(0);
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (n = 0; n < NPROBE; n++) begin
      if (probes[n].byp != bypass_q) begin
        drain();
        apb_write(R_BYPASS, DATA_W'(probes[n].byp));
      end
      push_sample(probes[n].smp, probes[n].seed, probes[n].known, probes[n].want);
    end

    per_phase = ITEMS / SETTINGS_N;
    level     = '0;
    for (phase = 0; phase < SETTINGS_N; phase++) begin
      drain();
      case (phase)
        0: plan_butterworth(0.05);
        1: for (k = 0; k < 2*SECTIONS; k++) plan_fb[k] = 0;
        2: plan_butterworth(0.2);
        3: plan_butterworth(0.1);
        4: ;
        5: for (k = 0; k < 2*SECTIONS; k++) plan_fb[k] = COEF_HI;
        6: for (k = 0; k < 2*SECTIONS; k++) plan_fb[k] = COEF_LO;
        7: for (k = 0; k < 2*SECTIONS; k++) plan_fb[k] = coef_pick(1'b0);
        8: plan_butterworth(0.45);
        default: for (k = 0; k < 2*SECTIONS; k++) plan_fb[k] = coef_pick(1'b1);
      endcase
      program_all(phase == 3);
      for (k = 0; k < per_phase; k++) begin
        n = phase * per_phase + k;
        set_idling(n * 3 / ITEMS);
        seed = (k == 0 && phase != 4) || ($urandom_range(0, 24) == 0);
        if (seed)
          level = SAMPLE_W'($urandom() >> 8);
        choice = $urandom_range(0, 9);
        case (choice)
          0:       s = S_MAX;
          1:       s = S_MIN;
          2, 3, 4: s = SAMPLE_W'($urandom() >> 8);
          default: s = level + SAMPLE_W'($urandom_range(0, 4095)) - SAMPLE_W'(2048);
        endcase
        push_sample(s, seed, 1'b0, '0);
      end
    end

    drain();
    if (errors == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
